// ----- src/gsbs_pkg.sv -----
package gsbs_pkg;

  // sweep geometry
  localparam int CAP_STEPS   = 5;
  localparam int TIME_STEPS  = 6;
  localparam int CHANNELS    = 3;
  localparam int NCH_MAX     = 3;
  localparam int NCH         = (CHANNELS < NCH_MAX) ? CHANNELS : NCH_MAX;
  localparam int SLOTS       = CAP_STEPS * TIME_STEPS;
  localparam int SLOT_CNT_W  = $clog2(SLOTS + 1);

  // register layout
  localparam int CAP_CODE_W   = 4;
  localparam int CAP_TABLE_N  = 5;
  localparam int TIME_W       = 10;
  localparam int TIME_TABLE_N = 6;
  localparam int CAP_TABLE_W  = CAP_CODE_W * CAP_TABLE_N;
  localparam int TIME_TABLE_W = TIME_W * TIME_TABLE_N;
  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 3;
  localparam int CHAN_W       = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = TIME_TABLE_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAP_TABLE  = 2'd0,
    REG_TIME_TABLE = 2'd1,
    REG_SETTLE     = 2'd2,
    REG_TARGET     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_TIMER  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_INTEGRATE = 2'd0,
    PH_ADC       = 2'd1,
    PH_STOP      = 2'd2
  } phase_t;

  typedef enum logic {
    ITEM_CONTROL = 1'b0,
    ITEM_REPORT  = 1'b1
  } item_type_t;

  // output tdata bit positions
  localparam int OD_LOAD_CAPS   = 0;
  localparam int OD_CAP_CODE    = 1;
  localparam int OD_RESET_PULSE = OD_CAP_CODE + CAP_CODE_W;
  localparam int OD_TIMER_LOAD  = OD_RESET_PULSE + 1;
  localparam int OD_TIMER_HALT  = OD_TIMER_LOAD + TIME_W;
  localparam int OD_ADC_TRIGGER = OD_TIMER_HALT + 1;
  localparam int OD_REP_CHANNEL = OD_ADC_TRIGGER + 1;
  localparam int OD_REP_VALUE   = OD_REP_CHANNEL + CHAN_W;
  localparam int OD_REP_CAP     = OD_REP_VALUE + SAMPLE_W;
  localparam int OD_REP_TIME    = OD_REP_CAP + STEP_W;
  localparam int OD_USED        = OD_REP_TIME + STEP_W;
  localparam int OUT_DATA_W     = ((OD_USED + 7) / 8) * 8;
  localparam int IN_DATA_W      = 3 * SAMPLE_W;

  typedef struct packed {
    item_type_t          item_type;
    logic                load_caps;
    logic [CAP_CODE_W-1:0] cap_code;
    logic                reset_pulse;
    logic [TIME_W-1:0]   timer_load;
    logic                timer_halt;
    logic                adc_trigger;
    logic [CHAN_W-1:0]   report_channel;
    logic [SAMPLE_W-1:0] report_value;
    logic [STEP_W-1:0]   report_cap_step;
    logic [STEP_W-1:0]   report_time_step;
    logic                last;
  } out_item_t;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- src/gain_sweep_best_sample_selector.sv -----
// Gain-sweep best-sample selector. Takes start, timer-expiry and ADC-sample
// events on s_axis (kind in tuser) and answers with control actions and, at
// the end of a 5 x 6 capacitor/time sweep, one best-sample report per
// channel (item_type in tuser, last in tlast). Each event is decoded in the
// cycle it is accepted and its results land in a 4-entry output queue, so
// one event is taken every clock; s_axis_tready drops only while the queue
// holds more than one result, as it does while the three reports of a
// finished sweep drain from the queue. Samples produce no output.
// Configuration writes are taken at any time (ready is always high) and
// must be done while the block is idle.
module gain_sweep_best_sample_selector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_a [15:0], sample_b [31:16], sample_c [47:32]
  input  logic [gsbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // load_caps [0], cap_code [4:1], reset_pulse [5], timer_load [15:6],
  // timer_halt [16], adc_trigger [17], report_channel [19:18],
  // report_value [35:20], report_cap_step [38:36], report_time_step [41:39]
  output logic [gsbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // item_type [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gsbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gsbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gsbs_pkg::*;

  // configuration
  logic [CAP_TABLE_W-1:0]  cap_code_table;
  logic [TIME_TABLE_W-1:0] time_table;
  logic [TIME_W-1:0]       settle_time;
  logic [SAMPLE_W-1:0]     target_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_code_table <= CAP_TABLE_W'(541200);
      time_table     <= TIME_TABLE_W'(64'd1126449877509785620);
      settle_time    <= TIME_W'(10);
      target_level   <= SAMPLE_W'(32767);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAP_TABLE:  cap_code_table <= cfg_data[CAP_TABLE_W-1:0];
        REG_TIME_TABLE: time_table     <= cfg_data[TIME_TABLE_W-1:0];
        REG_SETTLE:     settle_time    <= cfg_data[TIME_W-1:0];
        REG_TARGET:     target_level   <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and selector state
  phase_t                phase, phase_next;
  logic [STEP_W-1:0]     cap_step, cap_step_next;
  logic [STEP_W-1:0]     time_step, time_step_next;
  logic [SLOT_CNT_W-1:0] sample_count, sample_count_next;
  // slot of the next sample, kept already split into cap and time step
  logic [STEP_W-1:0]     samp_cap, samp_cap_next;
  logic [STEP_W-1:0]     samp_time, samp_time_next;
  logic [SAMPLE_W-1:0]   best_value [NCH];
  logic [SAMPLE_W-1:0]   best_value_next [NCH];
  logic [STEP_W-1:0]     best_cap [NCH];
  logic [STEP_W-1:0]     best_cap_next [NCH];
  logic [STEP_W-1:0]     best_time [NCH];
  logic [STEP_W-1:0]     best_time_next [NCH];

  // output queue
  out_item_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [FCNT_W-1:0]     count;

  out_item_t             push_item [NCH];
  logic [FCNT_W-1:0]     n_push;
  logic                  accept, pop;

  logic [SAMPLE_W-1:0]   samples [NCH_MAX];
  logic [SAMPLE_W:0]     dist_new [NCH];
  logic [SAMPLE_W:0]     dist_best [NCH];
  kind_t                 kind;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign kind   = kind_t'(s_axis_tuser);

  assign samples[0] = s_axis_tdata[SAMPLE_W-1:0];
  assign samples[1] = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign samples[2] = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

  always_comb begin
    for (int j = 0; j < NCH; j++) begin
      dist_new[j]  = (target_level > samples[j])
                     ? {1'b0, target_level} - {1'b0, samples[j]}
                     : {1'b0, samples[j]} - {1'b0, target_level};
      dist_best[j] = (target_level > best_value[j])
                     ? {1'b0, target_level} - {1'b0, best_value[j]}
                     : {1'b0, best_value[j]} - {1'b0, target_level};
    end
  end

  always_comb begin
    phase_next        = phase;
    cap_step_next     = cap_step;
    time_step_next    = time_step;
    sample_count_next = sample_count;
    samp_cap_next     = samp_cap;
    samp_time_next    = samp_time;
    best_value_next   = best_value;
    best_cap_next     = best_cap;
    best_time_next    = best_time;
    n_push            = '0;
    for (int j = 0; j < NCH; j++) begin
      push_item[j] = '0;
    end

    if (accept) begin
      case (kind)
        KIND_START: begin
          phase_next        = PH_INTEGRATE;
          cap_step_next     = '0;
          time_step_next    = '0;
          sample_count_next = '0;
          samp_cap_next     = '0;
          samp_time_next    = '0;
          for (int j = 0; j < NCH; j++) begin
            best_value_next[j] = '1;
            best_cap_next[j]   = '0;
            best_time_next[j]  = '0;
          end
          push_item[0].timer_load = settle_time;
          push_item[0].last       = 1'b1;
          n_push = FCNT_W'(1);
        end

        KIND_SAMPLE: begin
          if (sample_count < SLOT_CNT_W'(SLOTS)) begin
            for (int j = 0; j < NCH; j++) begin
              if (dist_new[j] < dist_best[j]) begin
                best_value_next[j] = samples[j];
                best_cap_next[j]   = samp_cap;
                best_time_next[j]  = samp_time;
              end
            end
            sample_count_next = sample_count + SLOT_CNT_W'(1);
            if (samp_time == STEP_W'(TIME_STEPS - 1)) begin
              samp_time_next = '0;
              samp_cap_next  = samp_cap + STEP_W'(1);
            end else begin
              samp_time_next = samp_time + STEP_W'(1);
            end
          end
        end

        KIND_TIMER: begin
          unique case (phase)
            PH_INTEGRATE: begin
              if (time_step == '0) begin
                push_item[0].load_caps = 1'b1;
                if (cap_step < STEP_W'(CAP_TABLE_N)) begin
                  push_item[0].cap_code =
                    CAP_CODE_W'(cap_code_table >> {cap_step, 2'b00});
                end
                cap_step_next = cap_step + STEP_W'(1);
              end
              push_item[0].reset_pulse = 1'b1;
              if (time_step < STEP_W'(TIME_TABLE_N)) begin
                push_item[0].timer_load =
                  TIME_W'(time_table >> (6'(time_step) * 6'(TIME_W)));
              end
              push_item[0].last = 1'b1;
              time_step_next = time_step + STEP_W'(1);
              phase_next     = PH_ADC;
              n_push         = FCNT_W'(1);
            end

            PH_ADC: begin
              push_item[0].timer_load  = settle_time;
              push_item[0].adc_trigger = 1'b1;
              push_item[0].last        = 1'b1;
              phase_next = PH_STOP;
              n_push     = FCNT_W'(1);
            end

            PH_STOP: begin
              phase_next = PH_INTEGRATE;
              if ({1'b0, cap_step} >= (STEP_W + 1)'(CAP_STEPS) &&
                  {1'b0, time_step} >= (STEP_W + 1)'(TIME_STEPS)) begin
                cap_step_next  = '0;
                time_step_next = '0;
                for (int j = 0; j < NCH; j++) begin
                  push_item[j].item_type        = ITEM_REPORT;
                  push_item[j].report_channel   = CHAN_W'(j);
                  push_item[j].report_value     = best_value[j];
                  push_item[j].report_cap_step  = best_cap[j];
                  push_item[j].report_time_step = best_time[j];
                end
                push_item[NCH-1].timer_halt = 1'b1;
                push_item[NCH-1].last       = 1'b1;
                n_push = FCNT_W'(NCH);
              end else begin
                if ({1'b0, time_step} >= (STEP_W + 1)'(TIME_STEPS)) begin
                  time_step_next = '0;
                end
                push_item[0].timer_load = settle_time;
                push_item[0].last       = 1'b1;
                n_push = FCNT_W'(1);
              end
            end

            default: ;
          endcase
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INTEGRATE;
      cap_step     <= '0;
      time_step    <= '0;
      sample_count <= '0;
      samp_cap     <= '0;
      samp_time    <= '0;
      for (int j = 0; j < NCH; j++) begin
        best_value[j] <= '1;
        best_cap[j]   <= '0;
        best_time[j]  <= '0;
      end
    end else begin
      phase        <= phase_next;
      cap_step     <= cap_step_next;
      time_step    <= time_step_next;
      sample_count <= sample_count_next;
      samp_cap     <= samp_cap_next;
      samp_time    <= samp_time_next;
      best_value   <= best_value_next;
      best_cap     <= best_cap_next;
      best_time    <= best_time_next;
    end
  end

  // queue: up to NCH writes at consecutive slots, one read at the head
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCH; k++) begin
      if (FCNT_W'(k) < n_push) begin
        fifo[wr_ptr + PTR_W'(k)] <= push_item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + n_push - FCNT_W'(pop);
    end
  end

  // room for a full report burst before taking another event
  assign s_axis_tready = (count <= FCNT_W'(FIFO_DEPTH - NCH));

  out_item_t head;
  assign head = fifo[rd_ptr];

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = head.item_type;
  assign m_axis_tlast  = head.last;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OD_LOAD_CAPS]                    = head.load_caps;
    m_axis_tdata[OD_CAP_CODE +: CAP_CODE_W]       = head.cap_code;
    m_axis_tdata[OD_RESET_PULSE]                  = head.reset_pulse;
    m_axis_tdata[OD_TIMER_LOAD +: TIME_W]         = head.timer_load;
    m_axis_tdata[OD_TIMER_HALT]                   = head.timer_halt;
    m_axis_tdata[OD_ADC_TRIGGER]                  = head.adc_trigger;
    m_axis_tdata[OD_REP_CHANNEL +: CHAN_W]        = head.report_channel;
    m_axis_tdata[OD_REP_VALUE +: SAMPLE_W]        = head.report_value;
    m_axis_tdata[OD_REP_CAP +: STEP_W]            = head.report_cap_step;
    m_axis_tdata[OD_REP_TIME +: STEP_W]           = head.report_time_step;
  end

endmodule

// ----- src/gsbs_checker.sv -----
module gsbs_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [gsbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tuser,
  input  logic                              m_axis_tlast
);
  import gsbs_pkg::*;

  // control actions always close their event
  a_ctrl_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ITEM_CONTROL) |-> m_axis_tlast)
    else $error("control item without tlast");

  // closing report halts the timer and belongs to the highest channel
  a_report_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ITEM_REPORT) && m_axis_tlast |->
      m_axis_tdata[OD_TIMER_HALT] &&
      (m_axis_tdata[OD_REP_CHANNEL +: CHAN_W] == CHAN_W'(NCH - 1)))
    else $error("final report malformed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind gain_sweep_best_sample_selector gsbs_checker u_gsbs_checker (.*);
